[hdl/matrix_multiply_add_stream_top_macros.svh]
// Assertion macros for the matrix multiply-add stream block.
// Used by the port-level checker; depends on nothing else.
`ifndef MATRIX_MULTIPLY_ADD_STREAM_TOP_MACROS_SVH
`define MATRIX_MULTIPLY_ADD_STREAM_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMAS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MMAS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mmas_pkg.sv]
// Shared types, codes and constants of the matrix multiply-add stream block.
// Depends on nothing; the RAM, controller, datapath, top level and checker refer to it by scoped names.
package mmas_pkg;

    localparam int MAX_DIM_DEF  = 64;
    localparam int MAX_SURF_DEF = 16;

    localparam int VAL_W      = 32;
    localparam int ACC_W      = 64;
    localparam int CFG_DATA_W = 7;
    localparam int FRAC_W     = 16;

    // Operation codes of an input item.
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_STREAM = 1'b1;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_COUPLING_DIM  = 1'b0,
        CFG_SURFACE_COUNT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic              operation;
        logic [5:0]        row;
        logic [6:0]        col;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [3:0]         result_row;
        logic [3:0]         result_col;
        logic               last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_WB
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic mac_issue;
        logic emit_read;
        logic emit_write;
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_mac;
        logic item_emit;
        logic issue_last;
        logic pipe_busy;
        logic out_free;
    } t_dp_status;

endpackage

[hdl/mmas_ram.sv]
// Generic single-clock RAM: one write port and one read port with registered read data.
// Depends on mmas_pkg for its default width and depth.
module mmas_ram #(
    parameter int  WIDTH = mmas_pkg::VAL_W,
    parameter int  DEPTH = mmas_pkg::MAX_SURF_DEF,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/mmas_ctrl.sv]
// Sequencing state machine of the matrix multiply-add stream block.
// Depends on mmas_pkg for the state type and the command and status structs.
module mmas_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  mmas_pkg::t_dp_status i_status,
    output mmas_pkg::t_ctrl_cmd  o_cmd,
    output logic                 o_in_stall
);

    mmas_pkg::t_state r_state;
    mmas_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmas_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            mmas_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.item_mac) begin
                        n_state = mmas_pkg::ST_MAC;
                    end else if (i_status.item_emit) begin
                        n_state = mmas_pkg::ST_EMIT_RD;
                    end
                end
            end
            mmas_pkg::ST_MAC: begin
                o_cmd.mac_issue = 1'b1;
                if (i_status.issue_last) begin
                    n_state = mmas_pkg::ST_DRAIN;
                end
            end
            mmas_pkg::ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = mmas_pkg::ST_IDLE;
                end
            end
            mmas_pkg::ST_EMIT_RD: begin
                o_cmd.emit_read = 1'b1;
                n_state         = mmas_pkg::ST_EMIT_WB;
            end
            mmas_pkg::ST_EMIT_WB: begin
                if (i_status.out_free) begin
                    o_cmd.emit_write = 1'b1;
                    n_state          = mmas_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mmas_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/mmas_dp.sv]
// Datapath of the matrix multiply-add stream block: configuration, boundary store,
// accumulator memory, multiply-accumulate pipeline and output register.
// Depends on mmas_pkg and mmas_ram.
module mmas_dp #(
    parameter int MAX_DIM      = mmas_pkg::MAX_DIM_DEF,
    parameter int MAX_SURFACES = mmas_pkg::MAX_SURF_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mmas_pkg::t_ctrl_cmd                 i_cmd,
    output mmas_pkg::t_dp_status                o_status,
    input  mmas_pkg::t_in_item                  i_in_item,
    input  logic                                i_cfg_valid,
    input  mmas_pkg::t_cfg_index                i_cfg_index,
    input  logic [mmas_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output mmas_pkg::t_out_item                 o_out_item
);

    localparam int CW       = 10;
    localparam int DIM_W    = $clog2(MAX_DIM + 1);
    localparam int VAC_W    = $clog2(MAX_SURFACES + 1);
    localparam int SA_W     = (MAX_SURFACES > 1) ? $clog2(MAX_SURFACES) : 1;
    localparam int ST_DEPTH = MAX_DIM * MAX_SURFACES;
    localparam int ST_AW    = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
    localparam int DIM_RST  = (64 > MAX_DIM) ? MAX_DIM : 64;
    localparam int VAC_RST  = (16 > MAX_SURFACES) ? MAX_SURFACES : 16;
    localparam int VAL_W    = mmas_pkg::VAL_W;
    localparam int ACC_W    = mmas_pkg::ACC_W;

    function automatic logic [CW-1:0] f_clamp(input logic [CW-1:0] v, input logic [CW-1:0] hi);
        logic [CW-1:0] res;
        begin
            if (v == '0) begin
                res = CW'(1);
            end else if (v > hi) begin
                res = hi;
            end else begin
                res = v;
            end
            return res;
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] f_sat_add(input logic signed [ACC_W-1:0] a,
                                                          input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W-1:0] s;
        begin
            s = a + b;
            if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
                s = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
            end
            return s;
        end
    endfunction

    // Configuration, held already clamped to the legal range.
    logic [DIM_W-1:0] r_dim;
    logic [VAC_W-1:0] r_vac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim <= DIM_W'(DIM_RST);
            r_vac <= VAC_W'(VAC_RST);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mmas_pkg::CFG_COUPLING_DIM: begin
                    r_dim <= DIM_W'(f_clamp(CW'(i_cfg_data), CW'(MAX_DIM)));
                end
                mmas_pkg::CFG_SURFACE_COUNT: begin
                    r_vac <= VAC_W'(f_clamp(CW'(i_cfg_data[4:0]), CW'(MAX_SURFACES)));
                end
                default: begin
                end
            endcase
        end
    end

    // Classification of the item on the input port.
    logic [CW-1:0] in_row;
    logic [CW-1:0] in_col;
    logic [CW-1:0] dim_e;
    logic [CW-1:0] vac_e;
    logic [CW-1:0] j_e;
    logic          is_stream;
    logic          row_ok;
    logic          item_mac;
    logic          item_emit;
    logic          load_ok;

    always_comb begin
        in_row    = CW'(i_in_item.row);
        in_col    = CW'(i_in_item.col);
        dim_e     = CW'(r_dim);
        vac_e     = CW'(r_vac);
        j_e       = in_col - dim_e;
        is_stream = (i_in_item.operation == mmas_pkg::OP_STREAM);
        row_ok    = in_row < vac_e;
        item_mac  = is_stream && row_ok && (in_col < dim_e);
        item_emit = is_stream && row_ok && (in_col >= dim_e) && (j_e < vac_e);
        load_ok   = (i_in_item.operation == mmas_pkg::OP_LOAD)
                    && (in_row < CW'(MAX_DIM)) && (in_col < CW'(MAX_SURFACES));
    end

    // Item registers captured on a transfer.
    logic signed [VAL_W-1:0] r_val;
    logic [3:0]              r_row;
    logic [3:0]              r_out_col;
    logic                    r_last;
    logic [SA_W-1:0]         r_emit_j;
    logic [ST_AW-1:0]        r_base;
    logic [SA_W-1:0]         r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_val     <= i_in_item.value;
            r_row     <= i_in_item.row[3:0];
            r_out_col <= j_e[3:0];
            r_last    <= (in_row == vac_e - CW'(1)) && (j_e == vac_e - CW'(1));
            r_emit_j  <= SA_W'(j_e);
            r_base    <= ST_AW'(ST_AW'(i_in_item.col) * ST_AW'(MAX_SURFACES));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.accept) begin
            r_cnt <= '0;
        end else if (i_cmd.mac_issue) begin
            r_cnt <= r_cnt + SA_W'(1);
        end
    end

    // Boundary store: written by load items, read once per accumulator column.
    logic [ST_AW-1:0] st_waddr;
    logic [ST_AW-1:0] st_raddr;
    logic [VAL_W-1:0] st_rdata;

    assign st_waddr = ST_AW'(ST_AW'(i_in_item.row) * ST_AW'(MAX_SURFACES)
                             + ST_AW'(i_in_item.col));
    assign st_raddr = r_base + ST_AW'(r_cnt);

    mmas_ram #(
        .WIDTH (VAL_W),
        .DEPTH (ST_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && load_ok),
        .i_waddr (st_waddr),
        .i_wdata (i_in_item.value),
        .i_re    (i_cmd.mac_issue),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // Multiply-accumulate pipeline: issue, multiply, accumulate and write back.
    logic                    r_s1_vld;
    logic                    r_s2_vld;
    logic [SA_W-1:0]         r_j1;
    logic [SA_W-1:0]         r_j2;
    logic signed [ACC_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc_s2;
    logic signed [VAL_W-1:0] st_x;
    logic signed [ACC_W-1:0] n_prod;
    logic signed [ACC_W-1:0] n_acc_sum;
    logic [ACC_W-1:0]        acc_rdata;
    logic [SA_W-1:0]         acc_raddr;
    logic [MAX_SURFACES-1:0] r_acc_vld;

    assign st_x      = st_rdata;
    assign n_prod    = r_val * st_x;
    assign n_acc_sum = f_sat_add(r_acc_s2, r_prod >>> mmas_pkg::FRAC_W);
    assign acc_raddr = i_cmd.mac_issue ? r_cnt : r_emit_j;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.mac_issue;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j1     <= r_cnt;
        r_j2     <= r_j1;
        r_prod   <= n_prod;
        r_acc_s2 <= r_acc_vld[r_j1] ? acc_rdata : '0;
    end

    // An accumulator whose flag is clear reads as zero; column zero clears all flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld <= '0;
        end else if (i_cmd.accept && item_mac && (in_col == '0)) begin
            r_acc_vld <= '0;
        end else if (r_s2_vld) begin
            r_acc_vld[r_j2] <= 1'b1;
        end
    end

    mmas_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_SURFACES)
    ) u_acc (
        .i_clk   (i_clk),
        .i_we    (r_s2_vld),
        .i_waddr (r_j2),
        .i_wdata (n_acc_sum),
        .i_re    (i_cmd.mac_issue || i_cmd.emit_read),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    // Result: accumulator plus offset element, saturated to 32 bits.
    logic signed [ACC_W-1:0] emit_acc;
    logic signed [ACC_W-1:0] emit_sum;
    logic [ACC_W-VAL_W:0]    emit_hi;
    logic signed [VAL_W-1:0] emit_val;

    always_comb begin
        emit_acc = r_acc_vld[r_emit_j] ? acc_rdata : '0;
        emit_sum = f_sat_add(emit_acc, ACC_W'(r_val));
        emit_hi  = emit_sum[ACC_W-1:VAL_W-1];
        if ((emit_hi == '0) || (emit_hi == '1)) begin
            emit_val = emit_sum[VAL_W-1:0];
        end else if (emit_sum[ACC_W-1]) begin
            emit_val = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            emit_val = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    logic                r_out_valid;
    mmas_pkg::t_out_item r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_write) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_write) begin
            r_out_item.result_value <= emit_val;
            r_out_item.result_row   <= r_row;
            r_out_item.result_col   <= r_out_col;
            r_out_item.last         <= r_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        o_status.item_mac   = item_mac;
        o_status.item_emit  = item_emit;
        o_status.issue_last = (CW'(r_cnt) == vac_e - CW'(1));
        o_status.pipe_busy  = r_s1_vld || r_s2_vld;
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

endmodule

[hdl/matrix_multiply_add_stream_top.sv]
// Load items may arrive back to back. A summed coefficient element holds the input while
// its products pass one at a time through the single 32x32 multiplier and the accumulator
// memory port and the multiply pipeline drains. An offset element holds the input through
// its accumulator read and until the output register has room for its result.
// Reset is synchronous and active low; it clears control state and the accumulator flags,
// while the boundary store keeps no defined contents until written.
//
// Top level of the matrix multiply-add stream block, F = B + A*X.
// Depends on mmas_pkg, mmas_ctrl, mmas_dp and mmas_ram.
module matrix_multiply_add_stream_top #(
    parameter int MAX_DIM      = mmas_pkg::MAX_DIM_DEF,
    parameter int MAX_SURFACES = mmas_pkg::MAX_SURF_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input item channel.
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  mmas_pkg::t_in_item              i_in_item,
    // Result item channel.
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output mmas_pkg::t_out_item             o_out_item,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  mmas_pkg::t_cfg_index            i_cfg_index,
    input  logic [mmas_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // The controller and the datapath talk only through these two structs.
    mmas_pkg::t_ctrl_cmd  cmd;
    mmas_pkg::t_dp_status status;

    // Configuration writes go straight into registers, so the port never holds off a transfer.
    // The user must issue writes only while the block is idle; the block does not enforce this.
    assign o_cfg_ready = 1'b1;

    // The controller walks each accepted item through its steps. A load is written to the
    // boundary store in the transfer cycle itself. A summed element issues one store and
    // accumulator read per surface, then waits for the multiply pipeline to drain.
    // An offset element reads its accumulator and then waits for room in the output register.
    mmas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // The datapath owns the configuration registers, both memories, the multiply pipeline
    // and the output register, which frees the input side while a result waits downstream.
    mmas_dp #(
        .MAX_DIM      (MAX_DIM),
        .MAX_SURFACES (MAX_SURFACES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

[hdl/mmas_checker.sv]
// Port-level assertions for the matrix multiply-add stream block, bound to the top level.
// Depends on mmas_pkg and the assertion macro header.
`include "matrix_multiply_add_stream_top_macros.svh"

module mmas_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input mmas_pkg::t_in_item              i_in_item,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input mmas_pkg::t_out_item             o_out_item
);

    // A result that is not taken stays on the port unchanged.
    `MMAS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "result changed while stalled")

    // A load needs no further steps, so the input is free right after its transfer.
    `MMAS_ASSERT_NXT(a_load_free, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_in_item.operation == mmas_pkg::OP_LOAD), !o_in_stall, "input stalled after a load")

    // A new result only appears at the end of work that held the input.
    `MMAS_ASSERT_IMP(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result appeared without work in progress")

    // The final element of the result matrix lies on its diagonal.
    `MMAS_ASSERT_IMP(a_last_diag, i_clk, i_rst_n, o_out_valid && o_out_item.last, o_out_item.result_row == o_out_item.result_col, "last result off the diagonal")

endmodule

bind matrix_multiply_add_stream_top mmas_checker u_checker (.*);
